FILE: src/mtx_pkg.sv
`default_nettype none
package mtx_pkg;
    localparam int MUTEX_COUNT_DEF = 16;
    localparam int WAIT_DEPTH_DEF  = 16;
    localparam int PID_BITS_DEF    = 8;

    typedef enum logic [1:0] {
        FN_ALLOC   = 2'd0,
        FN_DESTROY = 2'd1,
        FN_LOCK    = 2'd2,
        FN_UNLOCK  = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_RANGE      = 3'd1,
        ST_NOT_ALLOC  = 3'd2,
        ST_NO_FREE    = 3'd3,
        ST_LOCKED     = 3'd4,
        ST_WAIT_FULL  = 3'd5,
        ST_WAIT_EMPTY = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_READ,
        PH_WAKE
    } phase_t;
endpackage
`default_nettype wire

FILE: src/mtx_wait_mem.sv
`default_nettype none
module mtx_wait_mem
    import mtx_pkg::*;
#(
    parameter int AW = 8,
    parameter int DW = 8
)(
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);
    // pid store, uninitialized until written
    logic [DW-1:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

FILE: src/mutex_table_with_wait_queues.sv
`default_nettype none
// hardware mutex manager with per-mutex fifo wait queues. raise start while
// busy is low; the word is taken at that edge. a result appears on the result
// ports with done high for exactly one cycle, registered from the read phase
// (from the wake phase for an unlock that hands ownership to a waiter, since
// the waiter pid must be read from the wait memory). the receiver cannot
// stall: capture the result in the done cycle. busy stays high from
// acceptance to done, and a new word can be taken in the done cycle, so the
// block takes no new word before the last one is done. the per-mutex table
// sits in flip-flops, the wait queues in one synchronous memory with a
// registered read.
module mutex_table_with_wait_queues
    import mtx_pkg::*;
#(
    parameter int MUTEX_COUNT = MUTEX_COUNT_DEF,
    parameter int WAIT_DEPTH  = WAIT_DEPTH_DEF,
    parameter int PID_BITS    = PID_BITS_DEF
)(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [1:0] func,
    input  wire logic [7:0] mutex_id,
    input  wire logic [7:0] requester_pid,
    output logic            done,
    output logic [2:0]      status,
    output logic [7:0]      value,
    output logic            caller_blocks,
    output logic            woken_valid,
    output logic [7:0]      woken_pid
);
    localparam int MW = (MUTEX_COUNT > 1) ? $clog2(MUTEX_COUNT) : 1;
    localparam int QW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int CW = $clog2(WAIT_DEPTH + 1);
    localparam int FW = $clog2(MUTEX_COUNT + 1);

    // mutex table
    logic [MW-1:0]       free_ids_reg [MUTEX_COUNT];
    logic [MW-1:0]       fhead_reg, ftail_reg;
    logic [FW-1:0]       fcount_reg;
    logic                alloc_reg [MUTEX_COUNT];
    logic [7:0]          cnt_reg   [MUTEX_COUNT];
    logic [QW-1:0]       qhead_reg [MUTEX_COUNT];
    logic [QW-1:0]       qtail_reg [MUTEX_COUNT];
    logic [CW-1:0]       qcnt_reg  [MUTEX_COUNT];

    phase_t              ph_reg, ph_next;
    logic [1:0]          fn_reg;
    logic [7:0]          id_reg;
    logic [PID_BITS-1:0] pid_reg;
    logic [MW-1:0]       ix;
    logic                id_ok, q_has_room;
    logic                hand_over;

    // result registers
    logic                done_reg;
    logic [2:0]          st_reg;
    logic [7:0]          val_reg;
    logic                blk_reg, wv_reg, wake_out_reg;

    // wait memory
    logic                   wm_we;
    logic [MW+QW-1:0]       wm_waddr, wm_raddr;
    logic [PID_BITS-1:0]    wm_rdata;
    logic [PID_BITS-1:0]    wm_rdata_q;

    assign ix = id_reg[MW-1:0];
    assign id_ok      = ({1'b0, id_reg} < 9'(MUTEX_COUNT));
    assign q_has_room = (qcnt_reg[ix] < CW'(WAIT_DEPTH));
    assign wm_we    = (ph_reg == PH_READ) && (fn_reg == FN_LOCK) && id_ok &&
                      alloc_reg[ix] && (cnt_reg[ix] != 8'd0) && q_has_room &&
                      (cnt_reg[ix] != 8'hFF);
    assign wm_waddr = {ix, qtail_reg[ix]};
    assign wm_raddr = {ix, qhead_reg[ix]};

    mtx_wait_mem #(.AW(MW+QW), .DW(PID_BITS)) u_wmem (
        .clk   (clk),
        .we    (wm_we),
        .waddr (wm_waddr),
        .wdata (pid_reg),
        .raddr (wm_raddr),
        .rdata (wm_rdata)
    );

    // next phase: unlock handing over to a waiter needs the memory read cycle
    assign hand_over = (fn_reg == FN_UNLOCK) &&
                       id_ok && alloc_reg[ix] && (cnt_reg[ix] > 8'd1) &&
                       (qcnt_reg[ix] != CW'(0));

    always_comb
    begin
        ph_next = ph_reg;
        unique case (ph_reg)
            PH_IDLE: if (start) ph_next = PH_READ;
            PH_READ: ph_next = hand_over ? PH_WAKE : PH_IDLE;
            PH_WAKE: ph_next = PH_IDLE;
            default: ph_next = PH_IDLE;
        endcase
    end

    always_comb
    begin
        busy = (ph_reg != PH_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg       <= PH_IDLE;
            done_reg     <= 1'b0;
            fhead_reg    <= '0;
            ftail_reg    <= '0;
            fcount_reg   <= FW'(MUTEX_COUNT);
            wake_out_reg <= 1'b0;
            fn_reg       <= '0;
            id_reg       <= '0;
            pid_reg      <= '0;
            st_reg       <= '0;
            val_reg      <= '0;
            blk_reg      <= 1'b0;
            wv_reg       <= 1'b0;
            for (int i = 0; i < MUTEX_COUNT; i++)
            begin
                free_ids_reg[i] <= MW'(i);
                alloc_reg[i]    <= 1'b0;
                cnt_reg[i]      <= '0;
                qhead_reg[i]    <= '0;
                qtail_reg[i]    <= '0;
                qcnt_reg[i]     <= '0;
            end
        end
        else
        begin
            ph_reg       <= ph_next;
            done_reg     <= 1'b0;
            wake_out_reg <= 1'b0;
            if (ph_reg == PH_IDLE && start)
            begin
                fn_reg  <= func;
                id_reg  <= mutex_id;
                pid_reg <= PID_BITS'(requester_pid);
            end
            if (ph_reg == PH_WAKE)
            begin
                // memory data for the head waiter is valid now
                done_reg     <= 1'b1;
                wake_out_reg <= 1'b1;
                st_reg  <= ST_OK;
                blk_reg <= 1'b0;
                wv_reg  <= 1'b1;
                cnt_reg[ix]   <= cnt_reg[ix] - 8'd1;
                val_reg       <= cnt_reg[ix] - 8'd1;
                qhead_reg[ix] <= (32'(qhead_reg[ix]) + 1 >= WAIT_DEPTH) ?
                                 '0 : qhead_reg[ix] + QW'(1);
                qcnt_reg[ix]  <= qcnt_reg[ix] - CW'(1);
            end
            if (ph_reg == PH_READ && !hand_over)
            begin
                done_reg <= 1'b1;
                st_reg   <= ST_OK;
                val_reg  <= '0;
                blk_reg  <= 1'b0;
                wv_reg   <= 1'b0;
                if (fn_reg == FN_ALLOC)
                begin
                    if (fcount_reg == '0)
                    begin
                        st_reg <= ST_NO_FREE;
                    end
                    else
                    begin
                        val_reg <= 8'(free_ids_reg[fhead_reg]);
                        alloc_reg[free_ids_reg[fhead_reg]] <= 1'b1;
                        cnt_reg[free_ids_reg[fhead_reg]]   <= '0;
                        qhead_reg[free_ids_reg[fhead_reg]] <= '0;
                        qtail_reg[free_ids_reg[fhead_reg]] <= '0;
                        qcnt_reg[free_ids_reg[fhead_reg]]  <= '0;
                        fhead_reg  <= (32'(fhead_reg) + 1 >= MUTEX_COUNT) ?
                                      '0 : fhead_reg + MW'(1);
                        fcount_reg <= fcount_reg - FW'(1);
                    end
                end
                else if (!id_ok)
                begin
                    st_reg <= ST_RANGE;
                end
                else if (!alloc_reg[ix])
                begin
                    st_reg <= ST_NOT_ALLOC;
                end
                else
                begin
                    case (fn_reg)
                        FN_DESTROY:
                        begin
                            if (cnt_reg[ix] != 8'd0)
                            begin
                                st_reg  <= ST_LOCKED;
                                val_reg <= cnt_reg[ix];
                            end
                            else
                            begin
                                if (fcount_reg < FW'(MUTEX_COUNT))
                                begin
                                    free_ids_reg[ftail_reg] <= ix;
                                    ftail_reg  <= (32'(ftail_reg) + 1 >= MUTEX_COUNT) ?
                                                  '0 : ftail_reg + MW'(1);
                                    fcount_reg <= fcount_reg + FW'(1);
                                end
                                alloc_reg[ix] <= 1'b0;
                            end
                        end
                        FN_LOCK:
                        begin
                            if (cnt_reg[ix] == 8'd0)
                            begin
                                cnt_reg[ix] <= 8'd1;
                                val_reg     <= 8'd1;
                            end
                            else if (!q_has_room || cnt_reg[ix] == 8'hFF)
                            begin
                                st_reg  <= ST_WAIT_FULL;
                                val_reg <= cnt_reg[ix];
                            end
                            else
                            begin
                                qtail_reg[ix] <= (32'(qtail_reg[ix]) + 1 >= WAIT_DEPTH) ?
                                                 '0 : qtail_reg[ix] + QW'(1);
                                qcnt_reg[ix]  <= qcnt_reg[ix] + CW'(1);
                                cnt_reg[ix]   <= cnt_reg[ix] + 8'd1;
                                val_reg       <= cnt_reg[ix] + 8'd1;
                                blk_reg       <= 1'b1;
                            end
                        end
                        default:
                        begin
                            // unlock without a waiter to hand over to
                            if (cnt_reg[ix] > 8'd1)
                            begin
                                st_reg      <= ST_WAIT_EMPTY;
                                cnt_reg[ix] <= cnt_reg[ix] - 8'd1;
                                val_reg     <= cnt_reg[ix] - 8'd1;
                            end
                            else if (cnt_reg[ix] == 8'd1)
                            begin
                                cnt_reg[ix] <= 8'd0;
                            end
                        end
                    endcase
                end
            end
        end
    end

    always_comb
    begin
        done          = done_reg;
        status        = st_reg;
        value         = val_reg;
        caller_blocks = blk_reg;
        woken_valid   = wv_reg;
        woken_pid     = wake_out_reg ? 8'(wm_rdata_q) : 8'd0;
    end

    // hold the waiter pid for the done cycle
    always_ff @(posedge clk)
    begin
        if (ph_reg == PH_WAKE)
        begin
            wm_rdata_q <= wm_rdata;
        end
    end
endmodule
`default_nettype wire
